### hw/rtl/word_frequency_table_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the word frequency table
// Same-cycle and next-cycle implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef WORD_FREQUENCY_TABLE_CORE_MACROS_SVH
`define WORD_FREQUENCY_TABLE_CORE_MACROS_SVH

// pre implies post in the same cycle
`define WFT_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// pre implies post in the next cycle
`define WFT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

### hw/rtl/wft_pkg.sv
// ----------------------------------------------------------------------------
// wft_pkg
// Item types and status codes of the word frequency table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wft_pkg;

	localparam int WORD_BITS = 192;

	localparam logic OP_COUNT = 1'b0;
	localparam logic OP_READ  = 1'b1;

	localparam logic [1:0] STATUS_FOUND     = 2'd0;
	localparam logic [1:0] STATUS_NEW       = 2'd1;
	localparam logic [1:0] STATUS_FULL      = 2'd2;
	localparam logic [1:0] STATUS_BAD_INDEX = 2'd3;

	typedef struct packed {
		logic        op;
		logic [63:0] word_part_a;
		logic [63:0] word_part_b;
		logic [63:0] word_part_c;
		logic [6:0]  read_index;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [6:0]  entry_index;
		logic [15:0] entry_count;
		logic [63:0] entry_part_a;
		logic [63:0] entry_part_b;
		logic [63:0] entry_part_c;
		logic [7:0]  distinct_words;
	} out_item_t;

endpackage

### hw/rtl/wft_in_if.sv
// ----------------------------------------------------------------------------
// wft_in_if
// Valid/ready channel carrying count and read requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface wft_in_if;
	logic              valid;
	logic              ready;
	wft_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/wft_out_if.sv
// ----------------------------------------------------------------------------
// wft_out_if
// Valid/ready channel carrying table results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface wft_out_if;
	logic               valid;
	logic               ready;
	wft_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/word_frequency_table_core.sv
// ----------------------------------------------------------------------------
// word_frequency_table_core
// Table of distinct words with saturating occurrence counts.
// ----------------------------------------------------------------------------
// A count request normalizes its word (bytes after the first zero byte are
// cleared) and scans the filled entries in order, one entry per cycle through
// the single read port of the entry RAM and one shared key comparator. A hit
// moves to the update state, which writes the incremented count back and
// registers the result; a miss appends the word in the append state, or
// drops it when the table is full. A read request passes a read wait state
// and a read output state. The input is ready again as soon as the result is
// registered, and a stalled result output holds the sequencer in its last
// state. A finished result waits in the output register while the next
// request is taken. Memory contents need no clearing: only entries below the
// fill level are ever used.
`timescale 1ns / 1ps

`include "word_frequency_table_core_macros.svh"

module word_frequency_table_core #(
	parameter int TABLE_DEPTH = 128,
	parameter int KEY_BYTES   = 24,
	parameter int COUNT_WIDTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	wft_in_if.sink    item,
	wft_out_if.source result
);

	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W  = KEY_BYTES * 8;
	localparam int ENT_W  = COUNT_WIDTH + KEY_W;
	localparam logic [FILL_W-1:0] FILL_LIM = FILL_W'(TABLE_DEPTH);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_UPDATE = 3'd2;
	localparam logic [2:0] ST_APPEND = 3'd3;
	localparam logic [2:0] ST_RDWAIT = 3'd4;
	localparam logic [2:0] ST_RDOUT  = 3'd5;

	logic [2:0]             state_q;
	logic [KEY_W-1:0]       word_q;
	logic [6:0]             rd_idx_q;
	logic [FILL_W-1:0]      scan_q;
	logic                   cmp_vld_q;
	logic [IDX_W-1:0]       cmp_idx_q;
	logic [IDX_W-1:0]       hit_idx_q;
	logic [COUNT_WIDTH-1:0] hit_cnt_q;
	logic [FILL_W-1:0]      fill_q;
	logic                   out_vld_q;
	wft_pkg::out_item_t     out_q;

	logic                   we;
	logic [IDX_W-1:0]       waddr;
	logic [ENT_W-1:0]       wdata;
	logic [IDX_W-1:0]       raddr;
	logic [ENT_W-1:0]       rdata;
	logic [KEY_W-1:0]       rd_key;
	logic [COUNT_WIDTH-1:0] rd_cnt;
	logic                   key_eq;
	logic                   out_free;
	logic                   fin;
	wft_pkg::out_item_t     res_d;
	logic [COUNT_WIDTH-1:0] inc_cnt;
	logic [191:0]           rd_word;
	logic [KEY_W-1:0]       in_key;

	// keep byte i only when bytes 0..i are all nonzero and inside the key
	function automatic logic [KEY_W-1:0] norm_word(logic [191:0] w);
		logic [23:0]  nz;
		logic [23:0]  low;
		logic [191:0] r;
		r = '0;
		for (int i = 0; i < 24; i++) begin
			nz[i] = (i < KEY_BYTES) && (w[i*8 +: 8] != 8'h00);
		end
		for (int i = 0; i < 24; i++) begin
			low = 24'((25'd1 << (i + 1)) - 25'd1);
			if ((nz & low) == low) begin
				r[i*8 +: 8] = w[i*8 +: 8];
			end
		end
		return r[KEY_W-1:0];
	endfunction

	wft_entry_ram #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH (ENT_W)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign in_key   = norm_word({item.data.word_part_c, item.data.word_part_b,
		item.data.word_part_a});
	assign rd_key   = rdata[KEY_W-1:0];
	assign rd_cnt   = rdata[ENT_W-1 -: COUNT_WIDTH];
	assign rd_word  = 192'(rd_key);
	assign key_eq   = (rd_key == word_q);
	assign out_free = !out_vld_q || result.ready;
	assign inc_cnt  = (hit_cnt_q == '1) ? hit_cnt_q : hit_cnt_q + 1'b1;

	assign item.ready   = (state_q == ST_IDLE);
	assign result.valid = out_vld_q;
	assign result.data  = out_q;

	always_comb begin
		raddr = IDX_W'(scan_q);
		if (state_q == ST_RDWAIT || state_q == ST_RDOUT) begin
			raddr = IDX_W'(rd_idx_q);
		end
		we    = 1'b0;
		waddr = hit_idx_q;
		wdata = {inc_cnt, word_q};
		fin   = 1'b0;
		res_d = '0;
		res_d.distinct_words = 8'(fill_q);
		unique case (state_q)
			ST_UPDATE: begin
				fin = out_free;
				we  = out_free;
				res_d.status      = wft_pkg::STATUS_FOUND;
				res_d.entry_index = 7'(hit_idx_q);
				res_d.entry_count = 16'(inc_cnt);
			end
			ST_APPEND: begin
				fin = out_free;
				if (fill_q < FILL_LIM) begin
					we    = out_free;
					waddr = IDX_W'(fill_q);
					wdata = {COUNT_WIDTH'(1), word_q};
					res_d.status         = wft_pkg::STATUS_NEW;
					res_d.entry_index    = 7'(fill_q);
					res_d.entry_count    = 16'd1;
					res_d.distinct_words = 8'(fill_q + 1'b1);
				end else begin
					res_d.status = wft_pkg::STATUS_FULL;
				end
			end
			ST_RDOUT: begin
				fin = out_free;
				res_d.entry_index = rd_idx_q;
				if (32'(rd_idx_q) < 32'(fill_q)) begin
					res_d.status       = wft_pkg::STATUS_FOUND;
					res_d.entry_count  = 16'(rd_cnt);
					res_d.entry_part_a = rd_word[63:0];
					res_d.entry_part_b = rd_word[127:64];
					res_d.entry_part_c = rd_word[191:128];
				end else begin
					res_d.status = wft_pkg::STATUS_BAD_INDEX;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			cmp_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (fin) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					cmp_vld_q <= 1'b0;
					if (item.valid) begin
						state_q <= (item.data.op == wft_pkg::OP_READ) ? ST_RDWAIT : ST_SCAN;
					end
				end
				ST_SCAN: begin
					// issue one entry per cycle; compare the one read last cycle
					cmp_vld_q <= (scan_q < fill_q);
					if (cmp_vld_q && key_eq) begin
						state_q   <= ST_UPDATE;
						cmp_vld_q <= 1'b0;
					end else if (!cmp_vld_q && scan_q >= fill_q) begin
						state_q <= ST_APPEND;
					end
				end
				ST_UPDATE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_APPEND: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (fill_q < FILL_LIM) begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				ST_RDWAIT: begin
					state_q <= ST_RDOUT;
				end
				ST_RDOUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (fin) begin
			out_q <= res_d;
		end
		if (state_q == ST_IDLE) begin
			word_q   <= in_key;
			rd_idx_q <= item.data.read_index;
			scan_q   <= '0;
		end
		if (state_q == ST_SCAN) begin
			if (scan_q < fill_q) begin
				cmp_idx_q <= IDX_W'(scan_q);
				scan_q    <= scan_q + 1'b1;
			end
			if (cmp_vld_q && key_eq) begin
				hit_idx_q <= cmp_idx_q;
				hit_cnt_q <= rd_cnt;
			end
		end
	end

	`WFT_ASSERT_NOW(a_full_drop, clk, arst_n,
		result.valid && result.data.status == wft_pkg::STATUS_FULL,
		fill_q == FILL_LIM, "drop reported while table not full")
	`WFT_ASSERT_NEXT(a_fill_step, clk, arst_n,
		state_q == ST_APPEND && out_free && fill_q < FILL_LIM,
		fill_q == $past(fill_q) + 1'b1, "fill level did not advance on append")
	`WFT_ASSERT_NEXT(a_fill_hold, clk, arst_n,
		state_q != ST_APPEND,
		$stable(fill_q), "fill level changed outside append")
	`WFT_ASSERT_NOW(a_cmp_in_range, clk, arst_n,
		state_q == ST_SCAN && cmp_vld_q,
		32'(cmp_idx_q) < 32'(fill_q), "compared entry beyond fill level")

endmodule

### hw/rtl/wft_entry_ram.sv
// ----------------------------------------------------------------------------
// wft_entry_ram
// Single write port, single read port entry memory with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wft_entry_ram #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 208
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
